[hdl/lm3_pkg.sv]
// Shared types and constants of the 3x3 local maximum detector.
// Used by the top level, front end, back end and checker; depends on nothing.
`default_nettype none

package lm3_pkg;

	localparam int PIXEL_BITS   = 16;
	localparam int WIDTH_BITS   = 7;
	localparam int HEIGHT_BITS  = 16;
	localparam int ROW_BITS     = HEIGHT_BITS + 1;
	localparam int OUT_COL_BITS = 6;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INCLUDE_BORDERS = 2'd2;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic [WIDTH_BITS-1:0]  width;
		logic [HEIGHT_BITS-1:0] height;
		logic                   incl_borders;
		logic                   restart;
	} lm3_cfg_t;

endpackage

`default_nettype wire

[hdl/local_maximum_3x3_detector_core.sv]
// Top level of the 3x3 local maximum detector: configuration registers and
// the front end, queue and back end. Uses lm3_pkg, lm3_front, lm3_queue, lm3_back.
//
// Pixels enter in raster order, one beat per clock while the queue is not full; a flush beat
// before the frame's last pixel is dropped without a result. The result for a
// pixel leaves after the beat one row plus one pixel later, through the queue
// and the result register, and frame_width+1 flush beats drain the frame's last
// results. The rate is set by the line store, a RAM whose read is issued one
// column ahead so that each beat finds its column ready, and by the
// eight parallel comparisons in the back end. The line store needs no
// clearing pass. Writes to frame_width or frame_height restart the frame;
// configuration is taken at any clock but is meant for an idle block.
`default_nettype none

module local_maximum_3x3_detector_core
	import lm3_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int DATA_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [CFG_DAT_BITS-1:0]        cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           mode,
	input  wire logic signed [PIXEL_BITS-1:0]   pixel_value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [PIXEL_BITS-1:0]        out_value,
	output logic [HEIGHT_BITS-1:0]              out_row,
	output logic [OUT_COL_BITS-1:0]             out_column,
	output logic                                is_local_max,
	output logic                                on_border,
	output logic                                frame_end
);

	localparam int ENTRY_W = 9 * DATA_BITS;

	logic [WIDTH_BITS-1:0]  frame_width_q;
	logic [HEIGHT_BITS-1:0] frame_height_q;
	logic                   include_borders_q;
	logic                   cfg_write;
	lm3_cfg_t               cfg;
	logic                   q_push, q_full, q_pop, q_valid;
	logic [ENTRY_W-1:0]     push_data, head_data;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= WIDTH_BITS'(5);
			frame_height_q    <= HEIGHT_BITS'(5);
			include_borders_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:     frame_width_q     <= cfg_data[WIDTH_BITS-1:0];
				REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[HEIGHT_BITS-1:0];
				REG_INCLUDE_BORDERS: include_borders_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < WIDTH_BITS'(3)) begin
			cfg.width = WIDTH_BITS'(3);
		end else if (frame_width_q > WIDTH_BITS'(MAX_WIDTH)) begin
			cfg.width = WIDTH_BITS'(MAX_WIDTH);
		end else begin
			cfg.width = frame_width_q;
		end
		cfg.height       = (frame_height_q < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : frame_height_q;
		cfg.incl_borders = include_borders_q;
		cfg.restart      = cfg_write
			&& (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
	end

	lm3_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.DATA_BITS (DATA_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.pixel_value (pixel_value),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (push_data)
	);

	lm3_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (head_data)
	);

	lm3_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_data       (head_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_row      (out_row),
		.out_column   (out_column),
		.is_local_max (is_local_max),
		.on_border    (on_border),
		.frame_end    (frame_end)
	);

endmodule

`default_nettype wire

[hdl/lm3_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
`default_nettype none

module lm3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/lm3_front.sv]
// Front end: accepts beats, tracks the input raster position, keeps the line
// stores and window columns, and pushes one 3x3 window per result. Uses lm3_pkg, lm3_ram.
`default_nettype none

module lm3_front
	import lm3_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int DATA_BITS = 16,
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int ENTRY_W  = 9 * DATA_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lm3_cfg_t                     cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         mode,
	input  wire logic signed [PIXEL_BITS-1:0] pixel_value,
	input  wire logic                         q_full,
	output logic                              q_push,
	output logic             [ENTRY_W-1:0]    q_data
);

	logic [COL_W-1:0]            col_q, col_next;
	logic [ROW_BITS-1:0]         row_q, row_next;
	logic signed [DATA_BITS-1:0] pix_raw, pix, top_px, mid_px;
	logic signed [DATA_BITS-1:0] win_q [3][2];
	logic signed [DATA_BITS-1:0] new_col [3];
	logic [2*DATA_BITS-1:0]      rd_data;
	logic                        draining, accept, active, emit, wrap, frame_done;

	if (DATA_BITS <= PIXEL_BITS) begin : g_narrow
		assign pix_raw = pixel_value[DATA_BITS-1:0];
	end else begin : g_wide
		assign pix_raw = {{(DATA_BITS-PIXEL_BITS){pixel_value[PIXEL_BITS-1]}}, pixel_value};
	end

	assign in_ready = !q_full;
	assign top_px   = rd_data[2*DATA_BITS-1:DATA_BITS];
	assign mid_px   = rd_data[DATA_BITS-1:0];

	always_comb begin
		draining   = row_q >= ROW_BITS'(cfg.height);
		accept     = in_valid && in_ready;
		active     = accept && (draining || mode != MODE_FLUSH);
		pix        = draining ? '0 : pix_raw;
		emit       = (col_q == '0) ? (row_q >= ROW_BITS'(2)) : (row_q >= ROW_BITS'(1));
		wrap       = (WIDTH_BITS'(col_q) + WIDTH_BITS'(1)) >= cfg.width;
		frame_done = (col_q == '0) && (row_q == ROW_BITS'(cfg.height) + ROW_BITS'(1));
		col_next   = col_q;
		row_next   = row_q;
		if (cfg.restart) begin
			col_next = '0;
			row_next = '0;
		end else if (active) begin
			if (frame_done) begin
				col_next = '0;
				row_next = '0;
			end else if (wrap) begin
				col_next = '0;
				row_next = row_q + ROW_BITS'(1);
			end else begin
				col_next = col_q + COL_W'(1);
			end
		end
		new_col[0] = top_px;
		new_col[1] = mid_px;
		new_col[2] = pix;
		q_push = active && emit;
		q_data = {win_q[0][0], win_q[0][1], new_col[0],
			win_q[1][0], win_q[1][1], new_col[1],
			win_q[2][0], win_q[2][1], new_col[2]};
	end

	// The read is issued for the column of the next beat so that its data is
	// waiting in the read register when that beat arrives.
	lm3_ram #(
		.WIDTH (2 * DATA_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (active),
		.waddr (col_q),
		.wdata ({mid_px, pix}),
		.raddr (col_next),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= '0;
				win_q[i][1] <= '0;
			end
		end else begin
			col_q <= col_next;
			row_q <= row_next;
			if (active) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= new_col[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

[hdl/lm3_queue.sv]
// Two-entry queue that decouples the front end from the back end.
// Standalone; no package needed.
`default_nettype none

module lm3_queue #(
	parameter int WIDTH = 144
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic      [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

`default_nettype wire

[hdl/lm3_back.sv]
// Back end: takes windows from the queue, tracks the output raster position,
// runs the neighbor comparisons and holds the result register. Uses lm3_pkg.
`default_nettype none

module lm3_back
	import lm3_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int DATA_BITS = 16,
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int ENTRY_W  = 9 * DATA_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lm3_cfg_t                cfg,
	input  wire logic                    q_valid,
	input  wire logic [ENTRY_W-1:0]      q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [PIXEL_BITS-1:0] out_value,
	output logic [HEIGHT_BITS-1:0]       out_row,
	output logic [OUT_COL_BITS-1:0]      out_column,
	output logic                         is_local_max,
	output logic                         on_border,
	output logic                         frame_end
);

	logic [HEIGHT_BITS-1:0]      cur_row_q;
	logic [COL_W-1:0]            cur_col_q;
	logic                        out_valid_q, is_max_q, border_q, frame_end_q;
	logic [PIXEL_BITS-1:0]       value_q, centre_out;
	logic [HEIGHT_BITS-1:0]      row_q;
	logic [OUT_COL_BITS-1:0]     column_q;
	logic signed [DATA_BITS-1:0] nb [3][3];
	logic signed [DATA_BITS-1:0] centre;
	logic top_ex, bot_ex, left_ex, right_ex, border, last_px, peak, exists;

	if (DATA_BITS >= PIXEL_BITS) begin : g_trunc
		assign centre_out = centre[PIXEL_BITS-1:0];
	end else begin : g_ext
		assign centre_out = {{(PIXEL_BITS-DATA_BITS){1'b0}}, centre};
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nb[i][j] = q_data[(8 - (3*i + j))*DATA_BITS +: DATA_BITS];
			end
		end
		centre   = nb[1][1];
		top_ex   = cur_row_q != '0;
		bot_ex   = (ROW_BITS'(cur_row_q) + ROW_BITS'(1)) < ROW_BITS'(cfg.height);
		left_ex  = cur_col_q != '0;
		right_ex = (WIDTH_BITS'(cur_col_q) + WIDTH_BITS'(1)) < cfg.width;
		border   = !(top_ex && bot_ex && left_ex && right_ex);
		last_px  = !bot_ex && !right_ex;
		peak     = 1'b1;
		exists   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				exists = (i != 1 || j != 1) && (i != 0 || top_ex) && (i != 2 || bot_ex)
					&& (j != 0 || left_ex) && (j != 2 || right_ex);
				if (exists && !(centre > nb[i][j])) begin
					peak = 1'b0;
				end
			end
		end
		if (border && !cfg.incl_borders) begin
			peak = 1'b0;
		end
		q_pop = q_valid && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.restart) begin
				cur_row_q <= '0;
				cur_col_q <= '0;
			end else if (q_pop) begin
				if (last_px) begin
					cur_row_q <= '0;
					cur_col_q <= '0;
				end else if (!right_ex) begin
					cur_col_q <= '0;
					cur_row_q <= cur_row_q + HEIGHT_BITS'(1);
				end else begin
					cur_col_q <= cur_col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q     <= centre_out;
			row_q       <= cur_row_q;
			column_q    <= OUT_COL_BITS'(cur_col_q);
			is_max_q    <= peak;
			border_q    <= border;
			frame_end_q <= last_px;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = value_q;
	assign out_row      = row_q;
	assign out_column   = column_q;
	assign is_local_max = is_max_q;
	assign on_border    = border_q;
	assign frame_end    = frame_end_q;

endmodule

`default_nettype wire

[hdl/lm3_checker.sv]
// Port-level checks of the local maximum detector, bound to its top level.
// Uses lm3_pkg for field widths; depends on local_maximum_3x3_detector_core.
`default_nettype none

module lm3_checker
	import lm3_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [PIXEL_BITS-1:0]   out_value,
	input wire logic [HEIGHT_BITS-1:0]  out_row,
	input wire logic [OUT_COL_BITS-1:0] out_column,
	input wire logic                    on_border,
	input wire logic                    frame_end
);

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_row) && $stable(out_column) && $stable(frame_end))
		else $error("result beat changed while stalled");

	// A result appears from an empty output only after an input beat has passed the queue and the result register.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an input beat");

	// The frame's last pixel is a corner, so it lies on the border.
	a_end_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> on_border)
		else $error("frame end reported off the border");

	// Pixels of the first row or column are border pixels.
	a_first_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_row == '0 || out_column == '0) |-> on_border)
		else $error("first row or column pixel not marked as border");

endmodule

bind local_maximum_3x3_detector_core lm3_checker u_lm3_checker (.*);

`default_nettype wire

[verif/tb_local_maximum_3x3_detector_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 local maximum detector core.
// Depends on lm3_pkg and local_maximum_3x3_detector_core; every result beat is
// compared with a detector model kept in this file or with a directed table entry.

module tb_local_maximum_3x3_detector_core;
	import lm3_pkg::*;

	localparam int MAX_W = 64;
	localparam int RAND_ITEMS = 1800;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIR_ROWS = 27;
	localparam int FRAME_B_ROW = 14;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	typedef logic signed [PIXEL_BITS-1:0] pix_t;

	typedef struct packed {
		pix_t                    value;
		logic [HEIGHT_BITS-1:0]  row;
		logic [OUT_COL_BITS-1:0] column;
		logic                    peak;
		logic                    border;
		logic                    last;
	} lm_result_t;

	typedef struct packed {
		logic       mode;
		pix_t       value;
		logic       typed;
		lm_result_t result;
	} stim_row_t;

	// Frame A is 3x3 with borders tested, frame B is 3x3 with borders excluded from peaks.
	stim_row_t stim_tab [0:DIR_ROWS-1] = '{
		'{MODE_FLUSH, 16'sd0, 1'b0, '0},
		'{MODE_PIXEL, 16'sh7fff, 1'b0, '0},
		'{MODE_PIXEL, 16'sh8000, 1'b0, '0},
		'{MODE_PIXEL, 16'sd5, 1'b0, '0},
		'{MODE_PIXEL, 16'sh8000, 1'b0, '0},
		'{MODE_PIXEL, 16'sh8000, 1'b1, '{16'sh7fff, 16'd0, 6'd0, 1'b1, 1'b1, 1'b0}},
		'{MODE_PIXEL, -16'sd1, 1'b0, '0},
		'{MODE_PIXEL, 16'sd7, 1'b0, '0},
		'{MODE_PIXEL, 16'sd7, 1'b0, '0},
		'{MODE_PIXEL, 16'sh8000, 1'b0, '0},
		'{MODE_FLUSH, 16'sd0, 1'b0, '0},
		'{MODE_PIXEL, 16'sd12345, 1'b0, '0},
		'{MODE_FLUSH, 16'sd0, 1'b0, '0},
		'{MODE_FLUSH, 16'sd0, 1'b1, '{16'sh8000, 16'd2, 6'd2, 1'b0, 1'b1, 1'b1}},
		'{MODE_PIXEL, 16'sd9, 1'b0, '0},
		'{MODE_PIXEL, 16'sd1, 1'b0, '0},
		'{MODE_PIXEL, 16'sd2, 1'b0, '0},
		'{MODE_PIXEL, 16'sd3, 1'b0, '0},
		'{MODE_PIXEL, 16'sd50, 1'b0, '0},
		'{MODE_PIXEL, -16'sd4, 1'b0, '0},
		'{MODE_PIXEL, -16'sd5, 1'b0, '0},
		'{MODE_PIXEL, 16'sd6, 1'b0, '0},
		'{MODE_PIXEL, -16'sd7, 1'b1, '{16'sd50, 16'd1, 6'd1, 1'b1, 1'b0, 1'b0}},
		'{MODE_FLUSH, 16'sd0, 1'b0, '0},
		'{MODE_FLUSH, 16'sd0, 1'b0, '0},
		'{MODE_FLUSH, 16'sd0, 1'b0, '0},
		'{MODE_FLUSH, 16'sd0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DAT_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic mode;
	pix_t pixel_value;
	logic out_valid;
	logic out_ready;
	pix_t out_value;
	logic [HEIGHT_BITS-1:0] out_row;
	logic [OUT_COL_BITS-1:0] out_column;
	logic is_local_max;
	logic on_border;
	logic frame_end;

	logic beat_typed;
	lm_result_t beat_exp;

	lm_result_t due_results [$];
	int unsigned bad_cnt = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned hold_left = 0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;

	logic [WIDTH_BITS-1:0] geo_w;
	logic [HEIGHT_BITS-1:0] geo_h;
	logic geo_b;
	pix_t line_mem [0:2*MAX_W-1];
	pix_t win_q [0:2][0:2];
	int unsigned in_row, in_col, out_row_q, out_col_q;

	local_maximum_3x3_detector_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_value(out_value),
		.out_row(out_row),
		.out_column(out_column),
		.is_local_max(is_local_max),
		.on_border(on_border),
		.frame_end(frame_end)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_width(input logic [WIDTH_BITS-1:0] raw);
		if (raw < 3)
			return 3;
		if (raw > MAX_W)
			return MAX_W;
		return raw;
	endfunction

	function automatic pix_t rand_pixel();
		int unsigned s;
		s = $urandom_range(9);
		if (s < 5)
			return pix_t'($urandom);
		if (s < 9)
			return pix_t'(int'($urandom_range(6)) - 3);
		return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
	endfunction

	function automatic void restart_frame();
		in_row = 0;
		in_col = 0;
		out_row_q = 0;
		out_col_q = 0;
	endfunction

	task automatic predict_peak(input logic m, input pix_t px, output bit got,
			output lm_result_t res);
		int unsigned w, h, r, c, ci, cr, cc;
		bit emit;
		pix_t v, top, mid;
		pix_t snap [0:2][0:2];
		w = eff_width(geo_w);
		h = (geo_h < 3) ? 3 : geo_h;
		r = in_row;
		c = in_col;
		ci = c % MAX_W;
		got = 1'b0;
		res = '0;
		emit = 1'b0;
		if (r >= h || m == MODE_PIXEL) begin
			v = (r >= h) ? pix_t'(0) : px;
			top = line_mem[ci];
			mid = line_mem[MAX_W + ci];
			if (c == 0 && r >= 2) begin
				for (int i = 0; i < 3; i++) begin
					snap[i][0] = win_q[i][1];
					snap[i][1] = win_q[i][2];
					snap[i][2] = '0;
				end
				emit = 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] = win_q[i][1];
				win_q[i][1] = win_q[i][2];
			end
			win_q[0][2] = top;
			win_q[1][2] = mid;
			win_q[2][2] = v;
			if (c >= 1 && r >= 1) begin
				snap = win_q;
				emit = 1'b1;
			end
			line_mem[ci] = mid;
			line_mem[MAX_W + ci] = v;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			in_row = r;
			in_col = c;
			if (emit) begin
				cr = out_row_q;
				cc = out_col_q;
				res.value = snap[1][1];
				res.row = 16'(cr);
				res.column = 6'(cc);
				res.border = (cr == 0 || cr + 1 >= h || cc == 0 || cc + 1 >= w);
				res.peak = 1'b1;
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						if (!(i == 1 && j == 1) && !(i == 0 && cr < 1)
								&& !(i == 2 && cr + 1 >= h) && !(j == 0 && cc < 1)
								&& !(j == 2 && cc + 1 >= w) && !(snap[1][1] > snap[i][j]))
							res.peak = 1'b0;
					end
				end
				if (res.border && !geo_b)
					res.peak = 1'b0;
				res.last = (cr + 1 >= h) && (cc + 1 >= w);
				if (res.last) begin
					restart_frame();
				end else begin
					cc++;
					if (cc >= w) begin
						cc = 0;
						cr++;
					end
					out_row_q = cr;
					out_col_q = cc;
				end
				got = 1'b1;
			end
		end
	endtask

	task automatic note_fail(input string msg);
		bad_cnt++;
		if (bad_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : monitor
		bit got;
		lm_result_t calc, seen, want;
		if (!arst_n) begin
			for (int i = 0; i < 2 * MAX_W; i++)
				line_mem[i] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					win_q[i][j] = '0;
			end
			restart_frame();
			geo_w = 7'd5;
			geo_h = 16'd5;
			geo_b = 1'b1;
			due_results.delete();
			idle_cycles = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						geo_w = cfg_data[WIDTH_BITS-1:0];
						restart_frame();
					end
					REG_FRAME_HEIGHT: begin
						geo_h = cfg_data[HEIGHT_BITS-1:0];
						restart_frame();
					end
					REG_INCLUDE_BORDERS: begin
						geo_b = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				predict_peak(mode, pixel_value, got, calc);
				if (beat_typed)
					due_results.push_back(beat_exp);
				else if (got)
					due_results.push_back(calc);
			end
			if (out_valid && out_ready) begin
				seen = '{out_value, out_row, out_column, is_local_max, on_border, frame_end};
				if (due_results.size() == 0) begin
					note_fail($sformatf("unexpected result beat: value %0d row %0d col %0d",
						seen.value, seen.row, seen.column));
				end else begin
					want = due_results.pop_front();
					if (seen !== want)
						note_fail($sformatf({"result mismatch: expected value %0d row %0d ",
							"col %0d max %0b border %0b end %0b, got value %0d row %0d ",
							"col %0d max %0b border %0b end %0b"},
							want.value, want.row, want.column, want.peak, want.border,
							want.last, seen.value, seen.row, seen.column, seen.peak,
							seen.border, seen.last));
				end
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("local_maximum_3x3_detector_core: mismatch");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_beat(input logic m, input pix_t px, input logic typed,
			input lm_result_t exp_res);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pixel_value <= px;
		beat_typed <= typed;
		beat_exp <= exp_res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DAT_BITS-1:0] dat);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= dat;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int k, flip_at;
		int unsigned fed, frame_no, w_eff, h_eff, npix, ws, hs;
		bit clean, aborted;
		logic [WIDTH_BITS-1:0] cur_w;
		logic [HEIGHT_BITS-1:0] cur_h;
		logic cur_b;
		logic [CFG_DAT_BITS-1:0] dat;

		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_PIXEL;
		pixel_value = '0;
		beat_typed = 1'b0;
		beat_exp = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cfg_write(REG_FRAME_WIDTH, 16'hff80);
		cfg_write(REG_FRAME_HEIGHT, 16'd2);
		for (k = 0; k < DIR_ROWS; k++) begin
			if (k == FRAME_B_ROW) begin
				settle_block();
				cfg_write(REG_INCLUDE_BORDERS, 16'h0000);
			end
			send_beat(stim_tab[k].mode, stim_tab[k].value, stim_tab[k].typed,
				stim_tab[k].result);
		end
		settle_block();
		cfg_write(REG_SPARE, 16'($urandom));

		cur_w = 7'd0;
		cur_h = 16'd2;
		cur_b = 1'b0;
		clean = 1'b1;
		fed = 0;
		frame_no = 0;
		while (fed < RAND_ITEMS) begin
			case (frame_no % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 48; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 48; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			if (frame_no == 2) begin
				send_idle = 0;
				recv_stall = 0;
				settle_block();
				cur_w = 7'd64;
				cur_h = 16'd4;
				cur_b = 1'b1;
				cfg_write(REG_FRAME_WIDTH, 16'h0040);
				cfg_write(REG_FRAME_HEIGHT, cur_h);
				cfg_write(REG_INCLUDE_BORDERS, 16'h0001);
				hold_go = 1'b1;
			end else if (!(clean && $urandom_range(2) == 0)) begin
				ws = $urandom_range(19);
				if (ws < 14)
					cur_w = 7'($urandom_range(8, 3));
				else if (ws < 16)
					cur_w = 7'($urandom_range(2));
				else if (ws < 18)
					cur_w = 7'($urandom_range(64, 60));
				else if (ws == 18)
					cur_w = 7'($urandom_range(127, 65));
				else
					cur_w = 7'($urandom_range(32, 9));
				hs = $urandom_range(19);
				if (hs == 19)
					cur_h = $urandom_range(1) ? 16'hffff : 16'($urandom_range(65534, 100));
				else if (eff_width(cur_w) > 16)
					cur_h = 16'($urandom_range(4));
				else if (hs < 15)
					cur_h = 16'($urandom_range(6, 3));
				else if (hs < 17)
					cur_h = 16'($urandom_range(2));
				else
					cur_h = 16'($urandom_range(12, 7));
				cur_b = $urandom_range(1);
				settle_block();
				cfg_write(REG_FRAME_WIDTH, {9'($urandom), cur_w});
				cfg_write(REG_FRAME_HEIGHT, cur_h);
				dat = 16'($urandom);
				dat[0] = cur_b;
				cfg_write(REG_INCLUDE_BORDERS, dat);
			end
			w_eff = eff_width(cur_w);
			h_eff = (cur_h < 3) ? 3 : cur_h;
			npix = w_eff * h_eff;
			aborted = 1'b0;
			if (h_eff > 64 || (frame_no != 2 && $urandom_range(9) == 0)) begin
				npix = $urandom_range((h_eff > 64) ? 3 * w_eff + 5 : w_eff * h_eff - 1, 1);
				aborted = 1'b1;
			end
			flip_at = ($urandom_range(7) == 0) ? int'($urandom_range(npix - 1)) : -1;
			for (k = 0; k < npix; k++) begin
				if (k == flip_at) begin
					settle_block();
					cur_b = !cur_b;
					dat = 16'($urandom);
					dat[0] = cur_b;
					cfg_write(REG_INCLUDE_BORDERS, dat);
				end
				if ($urandom_range(24) == 0)
					send_beat(MODE_FLUSH, rand_pixel(), 1'b0, '0);
				send_beat(MODE_PIXEL, rand_pixel(), 1'b0, '0);
				fed++;
			end
			if (!aborted) begin
				for (k = 0; k <= w_eff; k++) begin
					send_beat(($urandom_range(4) == 0) ? MODE_PIXEL : MODE_FLUSH,
						rand_pixel(), 1'b0, '0);
					fed++;
				end
			end
			clean = !aborted;
			frame_no++;
		end

		settle_block();
		if (bad_cnt == 0)
			$display("local_maximum_3x3_detector_core: match");
		else
			$display("local_maximum_3x3_detector_core: mismatch");
		$finish;
	end

endmodule
